FILE: hdl/tsa_pkg.sv
// Shared types and codes for the three-mode watch timer.
// No dependencies; imported by tsa_update and the top level.
package tsa_pkg;

  typedef enum logic [1:0] {
    MODE_CD = 2'd0,
    MODE_SW = 2'd1,
    MODE_AL = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    EDIT_IDLE   = 2'd0,
    EDIT_SELECT = 2'd1,
    EDIT_ADJUST = 2'd2,
    EDIT_RUN    = 2'd3
  } edit_e;

  typedef enum logic [1:0] {
    KEY_BACK  = 2'd0,
    KEY_ENTER = 2'd1,
    KEY_LEFT  = 2'd2,
    KEY_RIGHT = 2'd3
  } key_e;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  // digit wrap moduli
  localparam logic [3:0] TENS_MOD    = 4'd6;
  localparam logic [3:0] ONES_MOD    = 4'd10;
  localparam logic [3:0] HR_TENS_MOD = 4'd3;
  localparam logic [3:0] HR_ONES_MOD = 4'd4;

  localparam logic [2:0] RING_LAST = 3'd6;

  typedef struct packed {
    logic       req_type;
    logic [1:0] key_code;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
  } item_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [2:0][1:0] edit;
    logic [2:0][1:0] cursor;
    logic [2:0][2:0] dig_a;
    logic [2:0][3:0] dig_b;
    logic [2:0][2:0] dig_c;
    logic [2:0][3:0] dig_d;
    logic [2:0]      run;
    logic            alarm;
    logic [2:0]      ring_cnt;
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] edit;
    logic [1:0] sel;
    logic [2:0] dig_a;
    logic [3:0] dig_b;
    logic [2:0] dig_c;
    logic [3:0] dig_d;
    logic       beep;
    logic       exit_req;
    logic       alarm;
    logic [2:0] run;
  } res_t;

endpackage

FILE: hdl/timer_stopwatch_alarm_controller.sv
// Three-mode watch timer top: input register, state registers, result register.
// A beat in the input register moves on to the result register once the result register is free.
// Throughput: one beat per cycle unless the output stalls; the input register frees as its beat moves on.
// Reset (rst_ni low, async): all modes idle and paused, digits zero, countdown shown.
// Depends on tsa_pkg and tsa_update.
module timer_stopwatch_alarm_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [1:0] key_code_i,
  input  logic [4:0] clock_hour_i,
  input  logic [5:0] clock_minute_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] shown_mode_o,
  output logic [1:0] shown_edit_o,
  output logic [1:0] shown_select_o,
  output logic [2:0] show_digit_a_o,
  output logic [3:0] show_digit_b_o,
  output logic [2:0] show_digit_c_o,
  output logic [3:0] show_digit_d_o,
  output logic       beep_o,
  output logic       exit_request_o,
  output logic       alarm_active_o,
  output logic [2:0] running_mask_o
);
  import tsa_pkg::*;

  item_t  item_q;
  logic   in_vld_q;
  state_t st_q, st_d;
  res_t   res_q, res_d;
  logic   out_vld_q;
  logic   advance;
  logic   in_take;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  tsa_update u_update (
    .cur_i  (st_q),
    .item_i (item_q),
    .nxt_o  (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      out_vld_q <= advance || (out_vld_q && out_stall_i);
      if (advance) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type     <= req_type_i;
      item_q.key_code     <= key_code_i;
      item_q.clock_hour   <= clock_hour_i;
      item_q.clock_minute <= clock_minute_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o    = out_vld_q;
  assign shown_mode_o   = res_q.mode;
  assign shown_edit_o   = res_q.edit;
  assign shown_select_o = res_q.sel;
  assign show_digit_a_o = res_q.dig_a;
  assign show_digit_b_o = res_q.dig_b;
  assign show_digit_c_o = res_q.dig_c;
  assign show_digit_d_o = res_q.dig_d;
  assign beep_o         = res_q.beep;
  assign exit_request_o = res_q.exit_req;
  assign alarm_active_o = res_q.alarm;
  assign running_mask_o = res_q.run;

  // a processed beat always lands in the result register
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed beat did not reach result register");

  // the alarm flag is only up while the alarm timer runs
  a_alarm_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.alarm |-> st_q.run[MODE_AL])
    else $error("alarm flag set with alarm timer stopped");

  // ring counter restarts after the seventh match
  a_ring_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ring_cnt <= RING_LAST)
    else $error("ring counter beyond last ring");

  // exit is only requested from idle or running edit state
  a_exit_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.exit_req) |->
      (res_q.edit == EDIT_IDLE || res_q.edit == EDIT_RUN))
    else $error("exit request from an edit state");

endmodule

FILE: hdl/tsa_update.sv
// Next-state and result logic for one beat: key handling, timer ticks, alarm match.
// Depends on tsa_pkg.
module tsa_update (
  input  tsa_pkg::state_t cur_i,
  input  tsa_pkg::item_t  item_i,
  output tsa_pkg::state_t nxt_o,
  output tsa_pkg::res_t   res_o
);
  import tsa_pkg::*;

  // (v + 1) mod m for v < 2*m
  function automatic logic [3:0] wrap_up(input logic [3:0] v, input logic [3:0] m);
    logic [4:0] s;
    logic [4:0] m2;
    s  = {1'b0, v} + 5'd1;
    m2 = {m, 1'b0};
    if (s >= m2) s = s - m2;
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[3:0];
  endfunction

  function automatic logic [3:0] wrap_dn(input logic [3:0] v, input logic [3:0] m);
    return (v == 4'd0) ? (m - 4'd1) : (v - 4'd1);
  endfunction

  logic [1:0] m;
  logic [1:0] e;
  logic       up;
  logic [1:0] c;
  logic [3:0] tmp;
  logic [1:0] hr_t;
  logic [3:0] hr_o;
  logic [2:0] mn_t;
  logic [3:0] mn_o;
  logic [4:0] hr_sub;
  logic [5:0] mn_sub;
  logic       match;
  logic       beep;
  logic       exit_req;
  state_t     n;

  // split clock inputs into decimal digits
  always_comb begin
    if (item_i.clock_hour >= 5'd30)      hr_t = 2'd3;
    else if (item_i.clock_hour >= 5'd20) hr_t = 2'd2;
    else if (item_i.clock_hour >= 5'd10) hr_t = 2'd1;
    else                                 hr_t = 2'd0;
    hr_sub = item_i.clock_hour - 5'({hr_t, 3'b000} + {hr_t, 1'b0});
    hr_o   = hr_sub[3:0];

    if (item_i.clock_minute >= 6'd60)      mn_t = 3'd6;
    else if (item_i.clock_minute >= 6'd50) mn_t = 3'd5;
    else if (item_i.clock_minute >= 6'd40) mn_t = 3'd4;
    else if (item_i.clock_minute >= 6'd30) mn_t = 3'd3;
    else if (item_i.clock_minute >= 6'd20) mn_t = 3'd2;
    else if (item_i.clock_minute >= 6'd10) mn_t = 3'd1;
    else                                   mn_t = 3'd0;
    mn_sub = item_i.clock_minute - 6'({mn_t, 3'b000} + {mn_t, 1'b0});
    mn_o   = mn_sub[3:0];
  end

  always_comb begin
    n        = cur_i;
    beep     = 1'b0;
    exit_req = 1'b0;
    tmp      = 4'd0;
    m        = (cur_i.mode == 2'd3) ? MODE_CD : cur_i.mode;
    n.mode   = m;
    e        = cur_i.edit[m];
    up       = (item_i.key_code == KEY_RIGHT);
    c        = cur_i.cursor[m];
    match    = 1'b0;

    if (item_i.req_type == REQ_KEY) begin
      beep = 1'b1;
      case (item_i.key_code)
        KEY_BACK: begin
          if (e == EDIT_IDLE || e == EDIT_RUN) exit_req = 1'b1;
          else n.edit[m] = e - 2'd1;
        end
        KEY_ENTER: begin
          if (e == EDIT_ADJUST) n.run[m] = 1'b1;
          if (e == EDIT_RUN) begin
            n.run[m] = 1'b0;
            if (m == MODE_AL) n.alarm = 1'b0;
          end
          n.edit[m] = e + 2'd1;
        end
        default: begin
          if (e == EDIT_IDLE || e == EDIT_RUN) begin
            case (m)
              MODE_CD: n.mode = up ? MODE_SW : MODE_AL;
              MODE_SW: n.mode = up ? MODE_AL : MODE_CD;
              default: n.mode = up ? MODE_CD : MODE_SW;
            endcase
          end else if (e == EDIT_SELECT) begin
            n.cursor[m] = up ? (c + 2'd1) : (c - 2'd1);
          end else begin
            case (c)
              2'd0: begin
                tmp = up ? wrap_up({1'b0, cur_i.dig_a[m]},
                                   (m == MODE_AL) ? HR_TENS_MOD : TENS_MOD)
                         : wrap_dn({1'b0, cur_i.dig_a[m]}, TENS_MOD);
                n.dig_a[m] = tmp[2:0];
              end
              2'd1: begin
                n.dig_b[m] = up ? wrap_up(cur_i.dig_b[m],
                                          (m == MODE_AL) ? HR_ONES_MOD : ONES_MOD)
                                : wrap_dn(cur_i.dig_b[m], ONES_MOD);
              end
              2'd2: begin
                tmp = up ? wrap_up({1'b0, cur_i.dig_c[m]}, TENS_MOD)
                         : wrap_dn({1'b0, cur_i.dig_c[m]}, TENS_MOD);
                n.dig_c[m] = tmp[2:0];
              end
              default: begin
                n.dig_d[m] = up ? wrap_up(cur_i.dig_d[m], ONES_MOD)
                                : wrap_dn(cur_i.dig_d[m], ONES_MOD);
              end
            endcase
          end
        end
      endcase
    end else begin
      // countdown: decrement mm:ss, stop at zero
      if (cur_i.run[MODE_CD]) begin
        if (cur_i.dig_a[MODE_CD] == 3'd0 && cur_i.dig_b[MODE_CD] == 4'd0 &&
            cur_i.dig_c[MODE_CD] == 3'd0 && cur_i.dig_d[MODE_CD] == 4'd0) begin
          n.cursor[MODE_CD] = 2'd0;
          n.edit[MODE_CD]   = EDIT_IDLE;
          n.mode            = MODE_CD;
          n.run[MODE_CD]    = 1'b0;
          beep              = 1'b1;
        end else if (cur_i.dig_d[MODE_CD] != 4'd0) begin
          n.dig_d[MODE_CD] = cur_i.dig_d[MODE_CD] - 4'd1;
        end else begin
          n.dig_d[MODE_CD] = 4'd9;
          if (cur_i.dig_c[MODE_CD] != 3'd0) begin
            n.dig_c[MODE_CD] = cur_i.dig_c[MODE_CD] - 3'd1;
          end else begin
            n.dig_c[MODE_CD] = 3'd5;
            if (cur_i.dig_b[MODE_CD] != 4'd0) begin
              n.dig_b[MODE_CD] = cur_i.dig_b[MODE_CD] - 4'd1;
            end else begin
              n.dig_b[MODE_CD] = 4'd9;
              n.dig_a[MODE_CD] = cur_i.dig_a[MODE_CD] - 3'd1;
            end
          end
        end
      end

      // stopwatch: increment mm:ss, 59:59 rolls to 00:00
      if (cur_i.run[MODE_SW]) begin
        if (cur_i.dig_d[MODE_SW] != 4'd9) begin
          n.dig_d[MODE_SW] = cur_i.dig_d[MODE_SW] + 4'd1;
        end else begin
          n.dig_d[MODE_SW] = 4'd0;
          if (cur_i.dig_c[MODE_SW] != 3'd5) begin
            n.dig_c[MODE_SW] = cur_i.dig_c[MODE_SW] + 3'd1;
          end else begin
            n.dig_c[MODE_SW] = 3'd0;
            if (cur_i.dig_b[MODE_SW] != 4'd9) begin
              n.dig_b[MODE_SW] = cur_i.dig_b[MODE_SW] + 4'd1;
            end else begin
              n.dig_b[MODE_SW] = 4'd0;
              n.dig_a[MODE_SW] = (cur_i.dig_a[MODE_SW] != 3'd5) ?
                                 (cur_i.dig_a[MODE_SW] + 3'd1) : 3'd0;
            end
          end
        end
      end

      // alarm acts last so it wins the shown mode
      if (cur_i.run[MODE_AL]) begin
        n.alarm = 1'b1;
        match = ({1'b0, hr_t} == cur_i.dig_a[MODE_AL]) && (hr_o == cur_i.dig_b[MODE_AL]) &&
                (mn_t == cur_i.dig_c[MODE_AL]) && (mn_o == cur_i.dig_d[MODE_AL]);
        if (match) begin
          n.cursor[MODE_AL] = 2'd0;
          n.edit[MODE_AL]   = EDIT_IDLE;
          n.mode            = MODE_AL;
          if (cur_i.ring_cnt >= RING_LAST) begin
            n.run[MODE_AL] = 1'b0;
            n.alarm        = 1'b0;
            n.ring_cnt     = 3'd0;
          end else begin
            n.ring_cnt = cur_i.ring_cnt + 3'd1;
          end
          beep = 1'b1;
        end
      end
    end
  end

  assign nxt_o = n;

  always_comb begin
    res_o.mode     = n.mode;
    res_o.edit     = n.edit[n.mode];
    res_o.sel      = n.cursor[n.mode];
    res_o.dig_a    = n.dig_a[n.mode];
    res_o.dig_b    = n.dig_b[n.mode];
    res_o.dig_c    = n.dig_c[n.mode];
    res_o.dig_d    = n.dig_d[n.mode];
    res_o.beep     = beep;
    res_o.exit_req = exit_req;
    res_o.alarm    = n.alarm;
    res_o.run      = n.run;
  end

endmodule

FILE: test/timer_stopwatch_alarm_controller_tb.sv
// Self-checking bench for the three-mode watch timer: key and tick beats are planned
// up front, driven with bursty valid/stall traffic and checked against a local watch model.
// Depends on tsa_pkg and timer_stopwatch_alarm_controller.
module timer_stopwatch_alarm_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsa_pkg::*;

  localparam int N_ITEMS     = 520;
  localparam int HOLD_CYCLES = 64;
  localparam int WATCHDOG    = 4000;
  localparam int TAIL        = 8;

  typedef struct {
    item_t it;
    int    gap;
    bit    drain;
    bit    hold_rx;
  } beat_plan_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       req_type = 1'b0;
  logic [1:0] key_code = 2'd0;
  logic [4:0] clock_hour = 5'd0;
  logic [5:0] clock_minute = 6'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] shown_mode;
  logic [1:0] shown_edit;
  logic [1:0] shown_select;
  logic [2:0] show_digit_a;
  logic [3:0] show_digit_b;
  logic [2:0] show_digit_c;
  logic [3:0] show_digit_d;
  logic       beep;
  logic       exit_request;
  logic       alarm_active;
  logic [2:0] running_mask;

  timer_stopwatch_alarm_controller i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .key_code_i     (key_code),
    .clock_hour_i   (clock_hour),
    .clock_minute_i (clock_minute),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .shown_mode_o   (shown_mode),
    .shown_edit_o   (shown_edit),
    .shown_select_o (shown_select),
    .show_digit_a_o (show_digit_a),
    .show_digit_b_o (show_digit_b),
    .show_digit_c_o (show_digit_c),
    .show_digit_d_o (show_digit_d),
    .beep_o         (beep),
    .exit_request_o (exit_request),
    .alarm_active_o (alarm_active),
    .running_mask_o (running_mask)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Watch model state
  // ---------------------------------------------------------------------------
  logic [1:0] w_mode;
  logic [1:0] w_edit [3];
  logic [1:0] w_cur  [3];
  logic [2:0] w_a    [3];
  logic [3:0] w_b    [3];
  logic [2:0] w_c    [3];
  logic [3:0] w_d    [3];
  logic       w_run  [3];
  logic       w_alarm;
  logic [2:0] w_rings;

  int n_keys, n_ticks, n_expiries, n_rings, n_wraps;

  function automatic int clock_secs(int m);
    return (w_a[m] * 10 + w_b[m]) * 60 + w_c[m] * 10 + w_d[m];
  endfunction

  function automatic void spread_secs(int m, int s);
    w_a[m] = 3'((s % 3600) / 600);
    w_b[m] = 4'((s % 600) / 60);
    w_c[m] = 3'((s % 60) / 10);
    w_d[m] = 4'(s % 10);
  endfunction

  function automatic int digit_at(int m, int pos);
    case (pos)
      0:       return w_a[m];
      1:       return w_b[m];
      2:       return w_c[m];
      default: return w_d[m];
    endcase
  endfunction

  // Applies one beat to the watch state and returns the display it leaves.
  function automatic res_t advance_watch(item_t it);
    res_t       r;
    key_e       k;
    int         m, dv, md, secs, hr, mi;
    logic [1:0] e;
    bit         up, ring, leave;
    ring  = 1'b0;
    leave = 1'b0;
    m     = w_mode;
    e     = w_edit[m];
    k     = key_e'(it.key_code);
    up    = (k == KEY_RIGHT);
    if (it.req_type == REQ_KEY) begin
      n_keys++;
      ring = 1'b1;
      case (k)
        KEY_BACK: begin
          if (e == EDIT_IDLE || e == EDIT_RUN) leave = 1'b1;
          else w_edit[m] = e - 2'd1;
        end
        KEY_ENTER: begin
          if (e == EDIT_ADJUST) w_run[m] = 1'b1;
          if (e == EDIT_RUN) begin
            w_run[m] = 1'b0;
            if (m == MODE_AL) w_alarm = 1'b0;
          end
          w_edit[m] = e + 2'd1;
        end
        default: begin
          if (e == EDIT_IDLE || e == EDIT_RUN) begin
            w_mode = 2'((m + (up ? 1 : 2)) % 3);
          end else if (e == EDIT_SELECT) begin
            w_cur[m] = w_cur[m] + (up ? 2'd1 : 2'd3);
          end else begin
            // alarm hour digits wrap short only when stepping up
            case (w_cur[m])
              2'd0:    md = (up && m == MODE_AL) ? HR_TENS_MOD : TENS_MOD;
              2'd1:    md = (up && m == MODE_AL) ? HR_ONES_MOD : ONES_MOD;
              2'd2:    md = TENS_MOD;
              default: md = ONES_MOD;
            endcase
            dv = digit_at(m, w_cur[m]);
            dv = up ? (dv + 1) % md : (dv + md - 1) % md;
            case (w_cur[m])
              2'd0:    w_a[m] = 3'(dv);
              2'd1:    w_b[m] = 4'(dv);
              2'd2:    w_c[m] = 3'(dv);
              default: w_d[m] = 4'(dv);
            endcase
          end
        end
      endcase
    end else begin
      n_ticks++;
      hr = it.clock_hour;
      mi = it.clock_minute;
      if (w_run[MODE_CD]) begin
        secs = clock_secs(MODE_CD);
        if (secs == 0) begin
          w_cur[MODE_CD]  = 2'd0;
          w_edit[MODE_CD] = EDIT_IDLE;
          w_mode          = MODE_CD;
          w_run[MODE_CD]  = 1'b0;
          ring            = 1'b1;
          n_expiries++;
        end else begin
          spread_secs(MODE_CD, secs - 1);
        end
      end
      if (w_run[MODE_SW]) begin
        secs = clock_secs(MODE_SW) + 1;
        if (secs == 3600) n_wraps++;
        spread_secs(MODE_SW, secs);
      end
      // alarm acts last, so it wins the shown mode on a shared tick
      if (w_run[MODE_AL]) begin
        w_alarm = 1'b1;
        if (hr / 10 == w_a[MODE_AL] && hr % 10 == w_b[MODE_AL] &&
            mi / 10 == w_c[MODE_AL] && mi % 10 == w_d[MODE_AL]) begin
          w_cur[MODE_AL]  = 2'd0;
          w_edit[MODE_AL] = EDIT_IDLE;
          w_mode          = MODE_AL;
          ring            = 1'b1;
          n_rings++;
          if (w_rings >= RING_LAST) begin
            w_run[MODE_AL] = 1'b0;
            w_alarm        = 1'b0;
            w_rings        = 3'd0;
          end else begin
            w_rings = w_rings + 3'd1;
          end
        end
      end
    end
    m          = w_mode;
    r.mode     = w_mode;
    r.edit     = w_edit[m];
    r.sel      = w_cur[m];
    r.dig_a    = w_a[m];
    r.dig_b    = w_b[m];
    r.dig_c    = w_c[m];
    r.dig_d    = w_d[m];
    r.beep     = ring;
    r.exit_req = leave;
    r.alarm    = w_alarm;
    r.run      = {w_run[MODE_AL], w_run[MODE_SW], w_run[MODE_CD]};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat planning (runs on the model at time zero, before reset is released)
  // ---------------------------------------------------------------------------
  beat_plan_t beat_q[$];
  res_t       display_q[$];
  bit         want_drain, want_hold;
  int         no_gap_left, burst_left;

  task automatic plan_beat(item_t it);
    beat_plan_t p;
    p.it       = it;
    p.drain    = want_drain;
    p.hold_rx  = want_hold;
    want_drain = 1'b0;
    want_hold  = 1'b0;
    if (no_gap_left > 0) begin
      p.gap = 0;
      no_gap_left--;
    end else if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      p.gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
    end else begin
      burst_left--;
      p.gap = 0;
    end
    void'(advance_watch(it));
    beat_q.push_back(p);
  endtask

  task automatic press(key_e k);
    item_t it;
    it.req_type     = REQ_KEY;
    it.key_code     = k;
    it.clock_hour   = 5'($urandom_range(0, 31));
    it.clock_minute = 6'($urandom_range(0, 63));
    plan_beat(it);
  endtask

  task automatic tick_at(int h, int mn);
    item_t it;
    it.req_type     = REQ_TICK;
    it.key_code     = 2'($urandom_range(0, 3));
    it.clock_hour   = 5'(h);
    it.clock_minute = 6'(mn);
    plan_beat(it);
  endtask

  task automatic go_to_mode(mode_e m);
    while (w_mode != m) begin
      if (w_edit[w_mode] == EDIT_SELECT || w_edit[w_mode] == EDIT_ADJUST) press(KEY_BACK);
      else press($urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT);
    end
  endtask

  // Walks the edit menu of one mode to load four digits, ending idle.
  task automatic set_time(mode_e m, int a, int b, int c, int d);
    int want[4];
    int tries;
    bit up_first;
    want = '{a, b, c, d};
    go_to_mode(m);
    if (w_edit[m] == EDIT_RUN) press(KEY_ENTER);
    if (w_edit[m] == EDIT_ADJUST) press(KEY_BACK);
    if (w_edit[m] == EDIT_IDLE) press(KEY_ENTER);
    for (int i = 0; i < 4; i++) begin
      while (w_cur[m] != i) press($urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT);
      press(KEY_ENTER);
      tries    = 0;
      up_first = $urandom_range(0, 1);
      // stepping down reaches every value, stepping up may not on alarm hours
      while (digit_at(m, i) != want[i]) begin
        press((up_first && tries < 6) ? KEY_RIGHT : KEY_LEFT);
        tries++;
      end
      press(KEY_BACK);
    end
    press(KEY_BACK);
  endtask

  task automatic start_timer(mode_e m);
    go_to_mode(m);
    while (!w_run[m]) press(KEY_ENTER);
  endtask

  task automatic stop_timer(mode_e m);
    go_to_mode(m);
    while (w_run[m]) press(KEY_ENTER);
  endtask

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  beat_plan_t next_plan;
  item_t      cur_beat;
  bit         staged;
  int         wait_left;
  int         n_predicted;
  int         n_checked;
  int         hold_reqs;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      req_type     <= 1'b0;
      key_code     <= 2'd0;
      clock_hour   <= 5'd0;
      clock_minute <= 6'd0;
      hold_reqs    <= 0;
      staged      = 1'b0;
      wait_left   = 0;
      n_predicted = 0;
    end else begin
      if (in_valid && !in_stall) begin
        display_q.push_back(advance_watch(cur_beat));
        n_predicted++;
      end
      if (!in_valid || !in_stall) begin
        if (!staged && beat_q.size() > 0) begin
          next_plan = beat_q.pop_front();
          staged    = 1'b1;
          wait_left = next_plan.gap;
          if (next_plan.hold_rx) hold_reqs <= hold_reqs + 1;
        end
        if (staged && wait_left == 0 && (!next_plan.drain || n_predicted == n_checked)) begin
          cur_beat      = next_plan.it;
          staged        = 1'b0;
          in_valid     <= 1'b1;
          req_type     <= cur_beat.req_type;
          key_code     <= cur_beat.key_code;
          clock_hour   <= cur_beat.clock_hour;
          clock_minute <= cur_beat.clock_minute;
        end else begin
          in_valid <= 1'b0;
          if (staged && wait_left > 0) wait_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern, with a long hold-off on request
  // ---------------------------------------------------------------------------
  int pat_kind, pat_left, pat_phase, hold_left, holds_seen;
  bit stall_nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      pat_kind   = 0;
      pat_left   = 0;
      pat_phase  = 0;
      hold_left  = 0;
      holds_seen = 0;
    end else begin
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(0, 3);
          pat_left = $urandom_range(4, 40);
        end
        pat_left--;
        pat_phase++;
        case (pat_kind)
          0:       stall_nxt = 1'b0;
          1:       stall_nxt = $urandom_range(0, 1);
          2:       stall_nxt = (pat_phase % 4 == 0);
          default: stall_nxt = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_stall <= stall_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  int   n_errors;
  int   n_beeps;
  res_t seen_want;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      n_checked <= n_checked + 1;
      if (display_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        n_errors++;
      end else begin
        seen_want = display_q.pop_front();
        if (seen_want.beep) n_beeps++;
        check_field("shown_mode",   seen_want.mode,     shown_mode);
        check_field("shown_edit",   seen_want.edit,     shown_edit);
        check_field("shown_select", seen_want.sel,      shown_select);
        check_field("show_digit_a", seen_want.dig_a,    show_digit_a);
        check_field("show_digit_b", seen_want.dig_b,    show_digit_b);
        check_field("show_digit_c", seen_want.dig_c,    show_digit_c);
        check_field("show_digit_d", seen_want.dig_d,    show_digit_d);
        check_field("beep",         seen_want.beep,     beep);
        check_field("exit_request", seen_want.exit_req, exit_request);
        check_field("alarm_active", seen_want.alarm,    alarm_active);
        check_field("running_mask", seen_want.run,      running_mask);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG) @(negedge clk_i);
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int hh, mn, k, next_drain;
    bit hold_done;
    mode_e pick;

    w_mode  = MODE_CD;
    w_alarm = 1'b0;
    w_rings = 3'd0;
    for (int i = 0; i < 3; i++) begin
      w_edit[i] = EDIT_IDLE;
      w_cur[i]  = 2'd0;
      w_a[i]    = 3'd0;
      w_b[i]    = 4'd0;
      w_c[i]    = 3'd0;
      w_d[i]    = 4'd0;
      w_run[i]  = 1'b0;
    end

    // directed: exit keys, clock extremes, cursor and digit wraps, alarm hour wrap
    press(KEY_BACK);
    tick_at(0, 0);
    tick_at(31, 63);
    press(KEY_LEFT);
    press(KEY_ENTER);
    press(KEY_LEFT);
    press(KEY_RIGHT);
    press(KEY_ENTER);
    press(KEY_RIGHT);
    press(KEY_RIGHT);
    press(KEY_RIGHT);
    press(KEY_LEFT);
    press(KEY_BACK);
    press(KEY_BACK);
    press(KEY_RIGHT);
    press(KEY_RIGHT);
    press(KEY_ENTER);
    press(KEY_ENTER);
    press(KEY_ENTER);
    tick_at(31, 63);
    press(KEY_BACK);
    press(KEY_ENTER);

    want_drain = 1'b1;
    next_drain = 120;
    hold_done  = 1'b0;
    while (beat_q.size() < N_ITEMS) begin
      if (!hold_done && beat_q.size() > 150) begin
        want_hold   = 1'b1;
        no_gap_left = 24;
        hold_done   = 1'b1;
      end
      if (beat_q.size() >= next_drain) begin
        want_drain = 1'b1;
        next_drain += 120;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          if ($urandom_range(0, 5) == 0) set_time(MODE_CD, 5, 9, 5, 9);
          else set_time(MODE_CD, 0, 0, $urandom_range(0, 1), $urandom_range(0, 9));
          start_timer(MODE_CD);
          k = clock_secs(MODE_CD) + $urandom_range(0, 3);
          if (k > 25) k = 25;
          repeat (k) tick_at($urandom_range(0, 31), $urandom_range(0, 63));
          stop_timer(MODE_CD);
        end
        2: begin
          if ($urandom_range(0, 3) == 0) set_time(MODE_SW, 0, 0, 0, 0);
          else set_time(MODE_SW, 5, 9, 5, $urandom_range(0, 9));
          start_timer(MODE_SW);
          repeat ($urandom_range(3, 15)) begin
            if ($urandom_range(0, 4) == 0) press(key_e'($urandom_range(0, 3)));
            tick_at($urandom_range(0, 31), $urandom_range(0, 63));
          end
          stop_timer(MODE_SW);
        end
        3, 4: begin
          hh = $urandom_range(0, 23);
          mn = $urandom_range(0, 59);
          set_time(MODE_AL, hh / 10, hh % 10, mn / 10, mn % 10);
          start_timer(MODE_AL);
          repeat ($urandom_range(2, 10)) begin
            if ($urandom_range(0, 3) != 0) tick_at(hh, mn);
            else tick_at($urandom_range(0, 31), $urandom_range(0, 63));
            // a key after a match leaves the ring count in place
            if ($urandom_range(0, 5) == 0) press(key_e'($urandom_range(0, 3)));
          end
          if ($urandom_range(0, 1)) stop_timer(MODE_AL);
        end
        5: begin
          hh = $urandom_range(0, 23);
          mn = $urandom_range(0, 59);
          k  = $urandom_range(0, 3);
          set_time(MODE_AL, hh / 10, hh % 10, mn / 10, mn % 10);
          start_timer(MODE_AL);
          set_time(MODE_CD, 0, 0, 0, k);
          start_timer(MODE_CD);
          repeat (k + $urandom_range(1, 3)) tick_at(hh, mn);
          stop_timer(MODE_AL);
          stop_timer(MODE_CD);
        end
        6, 7: begin
          repeat ($urandom_range(5, 20)) plan_beat(item_t'(14'($urandom)));
        end
        8: begin
          // half-finished edits with ticks in between
          pick = mode_e'($urandom_range(0, 2));
          go_to_mode(pick);
          repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 3) != 0) press(key_e'($urandom_range(0, 3)));
            else tick_at($urandom_range(0, 31), $urandom_range(0, 63));
          end
        end
        default: begin
          set_time(MODE_SW, $urandom_range(0, 5), $urandom_range(0, 9), 5, 5);
          start_timer(MODE_SW);
          set_time(MODE_CD, 0, $urandom_range(0, 1), $urandom_range(0, 5),
                   $urandom_range(0, 9));
          start_timer(MODE_CD);
          repeat ($urandom_range(6, 20)) begin
            if ($urandom_range(0, 2) == 0) press($urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT);
            tick_at($urandom_range(0, 31), $urandom_range(0, 63));
          end
          stop_timer(MODE_CD);
          stop_timer(MODE_SW);
        end
      endcase
    end

    // back to reset state for the live prediction
    w_mode  = MODE_CD;
    w_alarm = 1'b0;
    w_rings = 3'd0;
    for (int i = 0; i < 3; i++) begin
      w_edit[i] = EDIT_IDLE;
      w_cur[i]  = 2'd0;
      w_a[i]    = 3'd0;
      w_b[i]    = 4'd0;
      w_c[i]    = 3'd0;
      w_d[i]    = 4'd0;
      w_run[i]  = 1'b0;
    end
    n_keys     = 0;
    n_ticks    = 0;
    n_expiries = 0;
    n_rings    = 0;
    n_wraps    = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (!(beat_q.size() == 0 && !staged && !in_valid && n_checked == n_predicted))
      @(negedge clk_i);
    repeat (TAIL) @(negedge clk_i);
    if (display_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, display_q.size());
      n_errors++;
    end

    $display("Checked %0d beats: %0d key presses, %0d ticks, %0d beeps.",
             n_checked, n_keys, n_ticks, n_beeps);
    $display("Countdown expiries %0d, alarm rings %0d, stopwatch wraps %0d, mismatches %0d.",
             n_expiries, n_rings, n_wraps, n_errors);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
